// ----- hdl/aes_block_cipher_macros.svh -----
// Assertion macros for the AES block cipher checker
`ifndef AES_BLOCK_CIPHER_MACROS_SVH
`define AES_BLOCK_CIPHER_MACROS_SVH
// implication checked on every clock edge outside reset
`define AES_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define AES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hdl/aes_pkg.sv -----
// Shared types, constants and byte functions for the AES block cipher
`timescale 1ns / 1ps
package aes_pkg;
    localparam int RkDepthDefault = 60;
    localparam logic [2:0] CFG_KEY_LENGTH = 3'd0;
    localparam logic [2:0] CFG_KEY_WORD_0 = 3'd1;
    localparam logic [2:0] CFG_KEY_WORD_1 = 3'd2;
    localparam logic [2:0] CFG_KEY_WORD_2 = 3'd3;
    localparam logic [2:0] CFG_KEY_WORD_3 = 3'd4;
    localparam logic FUNC_ENC = 1'b0;
    localparam logic FUNC_DEC = 1'b1;

    typedef logic [7:0] t_byte;

    function automatic t_byte f_sbox(input t_byte a);
        t_byte t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic t_byte f_inv_sbox(input t_byte a);
        t_byte t [256];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[a];
    endfunction

    function automatic t_byte f_xt(input t_byte b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] f_sub_word(input logic [31:0] w);
        return {f_sbox(w[31:24]), f_sbox(w[23:16]), f_sbox(w[15:8]), f_sbox(w[7:0])};
    endfunction
endpackage

// ----- hdl/aes_key_exp.sv -----
// Key expansion sequencer: one round-key word per cycle into the key store
`timescale 1ns / 1ps
module aes_key_exp import aes_pkg::*; #(
    parameter int RK_DEPTH = RkDepthDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [1:0]                  i_key_length,
    input  logic [255:0]                i_key,
    input  logic [$clog2(RK_DEPTH)-1:0] i_rd_addr,
    input  logic                        i_rd_oob,
    output logic [31:0]                 o_rd_data,
    output logic                        o_done
);
    localparam int AW = $clog2(RK_DEPTH);

    logic [31:0] r_mem [RK_DEPTH];
    logic [31:0] r_win [8];      // last nk words
    logic [5:0]  r_idx, n_idx;
    logic [2:0]  r_pos;          // i mod nk
    logic [7:0]  r_rc;
    logic        r_busy, r_done, r_oob;
    logic [31:0] r_rd;
    logic [3:0]  nk;
    logic [2:0]  win_last;       // window slot of the newest word
    logic [5:0]  total;
    logic [31:0] prev, t, w_new, w_far;
    logic [1:0]  code;

    assign code     = (i_key_length == 2'd3) ? 2'd2 : i_key_length;
    assign nk       = 4'd4 + {1'b0, code, 1'b0};
    assign win_last = nk[2:0] - 3'd1;
    assign total    = 6'd44 + {1'b0, code, 3'b000};
    assign prev     = r_win[win_last];
    assign w_far    = r_win[0];

    always_comb begin
        t = prev;
        if (r_pos == 3'd0) begin
            t = f_sub_word({prev[23:0], prev[31:24]}) ^ {r_rc, 24'd0};
        end else if (nk == 4'd8 && r_pos == 3'd4) begin
            t = f_sub_word(prev);
        end
        w_new = w_far ^ t;
        n_idx = r_idx + 6'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_idx  <= 6'd0;
        end else if (r_busy) begin
            r_idx <= n_idx;
            if (n_idx == total) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // shift window; key words first, then derived words
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            for (int k = 0; k < 8; k++) begin
                r_win[k] <= i_key[255 - 32*k -: 32];
            end
            r_pos <= 3'd0;
            r_rc  <= 8'h01;
        end else if (r_busy) begin
            if (r_idx >= {2'b0, nk}) begin
                for (int k = 0; k < 7; k++) begin
                    r_win[k] <= (k[2:0] == win_last) ? w_new : r_win[k+1];
                end
                if (win_last == 3'd7) begin
                    r_win[7] <= w_new;
                end
                r_pos <= (r_pos == nk[2:0] - 3'd1 || (nk == 4'd8 && r_pos == 3'd7))
                         ? 3'd0 : r_pos + 3'd1;
                if (r_pos == 3'd0) begin
                    r_rc <= f_xt(r_rc);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && r_idx < RK_DEPTH[5:0]) begin
            r_mem[r_idx[AW-1:0]] <= (r_idx < {2'b0, nk}) ? r_win[r_idx[2:0]] : w_new;
        end
        r_rd  <= r_mem[i_rd_addr];
        r_oob <= i_rd_oob;
    end

    assign o_rd_data = r_oob ? 32'd0 : r_rd;
    assign o_done    = r_done;
endmodule

// ----- hdl/aes_round.sv -----
// Column-wide round unit: combinational sub, mix and key add for one state column
`timescale 1ns / 1ps
module aes_round import aes_pkg::*; (
    input  logic [31:0] i_col,     // already row-shifted column
    input  logic [31:0] i_key,
    input  logic        i_dec,
    input  logic        i_mix,
    output logic [31:0] o_col
);
    t_byte s [4];
    t_byte a [4];
    t_byte m [4];
    t_byte x2 [4], x4 [4], x8 [4];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            s[r] = i_dec ? f_inv_sbox(i_col[31-8*r -: 8]) : f_sbox(i_col[31-8*r -: 8]);
            // decrypt adds key before inverse mix
            a[r] = i_dec ? (s[r] ^ i_key[31-8*r -: 8]) : s[r];
            x2[r] = f_xt(a[r]);
            x4[r] = f_xt(x2[r]);
            x8[r] = f_xt(x4[r]);
        end
        for (int r = 0; r < 4; r++) begin
            if (!i_dec) begin
                m[r] = x2[r] ^ (x2[(r+1)%4] ^ a[(r+1)%4]) ^ a[(r+2)%4] ^ a[(r+3)%4];
            end else begin
                m[r] = (x8[r] ^ x4[r] ^ x2[r])
                     ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4])
                     ^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4])
                     ^ (x8[(r+3)%4] ^ a[(r+3)%4]);
            end
        end
        for (int r = 0; r < 4; r++) begin
            if (i_dec) begin
                o_col[31-8*r -: 8] = i_mix ? m[r] : a[r];
            end else begin
                o_col[31-8*r -: 8] = (i_mix ? m[r] : a[r]) ^ i_key[31-8*r -: 8];
            end
        end
    end
endmodule

// ----- hdl/aes_block_cipher.sv -----
// Top level of the AES block cipher: config registers, sequencer and state
`timescale 1ns / 1ps
// Usage:
//  Config: write key_length (index 0) and key words (1..4) on i_cfg_* with
//  valid/ready while idle; ready is high when no block is in flight and no result is shown.
//  Command: a transfer happens when i_start is high and o_busy is low; func
//  selects encrypt (0) or decrypt (1).
//  Each block first expands the key: 44/52/60 words, one word a cycle, from
//  the key-expansion sequencer into its key store RAM.
//  The rounds then run column by column through one shared column unit,
//  each column preceded by a key-store read (ST_RD, then ST_OP), plus
//  one initial key-add round. A new start is taken in the result cycle.
//  One block at a time; o_busy stays high until the strobe.
//  The result shows for one cycle with o_valid; it cannot be stalled.
//  Reset (i_rst_n low, synchronous) clears key length, key and control;
//  the key store needs no clearing since it is rebuilt for every block.
module aes_block_cipher import aes_pkg::*; #(
    parameter int ROUND_KEY_DEPTH = RkDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_func,
    input  logic [63:0] i_block_hi,
    input  logic [63:0] i_block_lo,
    output logic        o_valid,
    output logic [63:0] o_out_hi,
    output logic [63:0] o_out_lo,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    localparam int AW = $clog2(ROUND_KEY_DEPTH);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_KEY  = 2'd1;
    localparam logic [1:0] ST_RD   = 2'd2;   // key read issued
    localparam logic [1:0] ST_OP   = 2'd3;   // column processed

    logic [1:0]   r_state;
    logic [1:0]   r_klen;
    logic [255:0] r_key;
    logic         r_dec;
    logic [127:0] r_s, r_n;        // current and next-round state
    logic [3:0]   r_round;         // rounds done so far, 0 = initial key add
    logic [1:0]   r_col;
    logic         r_valid;
    logic [3:0]   nr;
    logic [3:0]   krnd;
    logic [5:0]   kidx;
    logic [31:0]  rk, col_in, col_out, init_col;
    logic         kdone, go;

    assign nr = (r_klen == 2'd0) ? 4'd10 : ((r_klen == 2'd1) ? 4'd12 : 4'd14);
    assign go = i_start && !o_busy;

    // round key used: encrypt walks up, decrypt walks down
    assign krnd = r_dec ? (nr - r_round) : r_round;
    assign kidx = {krnd, r_col};

    aes_key_exp #(.RK_DEPTH(ROUND_KEY_DEPTH)) u_kexp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_key_length(r_klen),
        .i_key       (r_key),
        .i_rd_addr   (kidx[AW-1:0]),
        .i_rd_oob    (kidx >= ROUND_KEY_DEPTH[5:0]),
        .o_rd_data   (rk),
        .o_done      (kdone)
    );

    // gather the row-shifted column from the current state
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            logic [1:0] sc;
            sc = r_dec ? (r_col - r[1:0]) : (r_col + r[1:0]);
            col_in[31-8*r -: 8] = r_s[127 - 32*sc - 8*r -: 8];
        end
        init_col = r_s[127 - 32*r_col -: 32] ^ rk;
    end

    aes_round u_round (
        .i_col(col_in),
        .i_key(rk),
        .i_dec(r_dec),
        .i_mix(r_round != nr),
        .o_col(col_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_klen  <= 2'd0;
            r_key   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KEY_LENGTH: r_klen <= (i_cfg_data[1:0] == 2'd3) ? 2'd2 : i_cfg_data[1:0];
                CFG_KEY_WORD_0: r_key[255:192] <= i_cfg_data;
                CFG_KEY_WORD_1: r_key[191:128] <= i_cfg_data;
                CFG_KEY_WORD_2: r_key[127:64]  <= i_cfg_data;
                CFG_KEY_WORD_3: r_key[63:0]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: if (go) begin
                    r_state <= ST_KEY;
                    r_dec   <= i_func;
                    r_s     <= {i_block_hi, i_block_lo};
                end
                ST_KEY: if (kdone) begin
                    r_state <= ST_RD;
                    r_round <= 4'd0;
                    r_col   <= 2'd0;
                end
                ST_RD: r_state <= ST_OP;
                ST_OP: begin
                    r_state <= ST_RD;
                    r_col   <= r_col + 2'd1;
                    if (r_col == 2'd3) begin
                        if (r_round == 4'd0) begin
                            r_s <= {r_n[127:32], init_col};
                        end else begin
                            r_s <= {r_n[127:32], col_out};
                        end
                        r_round <= r_round + 4'd1;
                        if (r_round == nr) begin
                            r_state <= ST_IDLE;
                            r_valid <= 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OP) begin
            r_n[127 - 32*r_col -: 32] <= (r_round == 4'd0) ? init_col : col_out;
        end
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE) && !r_valid;
    assign o_valid     = r_valid;
    assign o_out_hi    = r_s[127:64];
    assign o_out_lo    = r_s[63:0];
endmodule

// ----- hdl/aes_chk.sv -----
// Port-level checker for the AES block cipher, bound to the top level
`timescale 1ns / 1ps
`include "aes_block_cipher_macros.svh"
module aes_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid,
    input logic o_cfg_ready
);
    `AES_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `AES_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)
    `AES_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !o_busy && !o_cfg_ready)
    `AES_ASSERT_IMP(a_cfg_idle, i_clk, i_rst_n, o_cfg_ready, !o_busy)
endmodule

bind aes_block_cipher aes_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
    .o_busy(o_busy), .o_valid(o_valid), .o_cfg_ready(o_cfg_ready)
);

// ----- tb/aes_block_cipher_tb.sv -----
// Self-checking testbench for the AES block cipher: encrypt/decrypt over all key lengths
`timescale 1ns / 1ps
module aes_block_cipher_tb import aes_pkg::*;;

    // config indexes past the last register; writes there must be dropped
    localparam logic [2:0] CFG_SPARE_LO = 3'd5;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;
    // key length codes
    localparam logic [1:0] KLEN_128 = 2'd0;
    localparam logic [1:0] KLEN_192 = 2'd1;
    localparam logic [1:0] KLEN_256 = 2'd2;
    localparam logic [1:0] KLEN_SAT = 2'd3;
    // quiet cycles before a config write, more than the longest block latency
    localparam int SETTLE = 250;

    typedef enum logic [1:0] {ITEM_BLOCK, ITEM_CFG, ITEM_DRAIN} t_item_kind;

    typedef struct {
        t_item_kind  kind;
        logic        func;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [2:0]  idx;
        logic [63:0] data;
        int          gap;
    } t_stim_item;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_cipher_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_func = FUNC_ENC;
    logic [63:0] i_block_hi = '0;
    logic [63:0] i_block_lo = '0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = CFG_KEY_LENGTH;
    logic [63:0] i_cfg_data = '0;
    logic        o_busy;
    logic        o_valid;
    logic [63:0] o_out_hi;
    logic [63:0] o_out_lo;
    logic        o_cfg_ready;

    aes_block_cipher u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_func      (i_func),
        .i_block_hi  (i_block_hi),
        .i_block_lo  (i_block_lo),
        .o_valid     (o_valid),
        .o_out_hi    (o_out_hi),
        .o_out_lo    (o_out_lo),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Cipher model: own key registers, S-boxes built from GF(2^8) math
    // ---------------------------------------------------------------
    logic [1:0]  key_len_reg = KLEN_128;
    logic [63:0] key_regs [4] = '{default: '0};
    logic [31:0] sched [60];
    logic [7:0]  fwd_box [256];
    logic [7:0]  inv_box [256];

    t_stim_item  work_q [$];
    t_cipher_out pending_q [$];
    int          fail_count = 0;

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] m);
        logic [7:0] acc;
        acc = '0;
        for (int k = 0; k < 8; k++) begin
            if (m[k]) acc ^= a;
            a = xtime(a);
        end
        return acc;
    endfunction

    // S-box: multiplicative inverse (a^254) then the affine map
    initial begin
        logic [7:0] inv_v, p, s;
        for (int a = 0; a < 256; a++) begin
            inv_v = 8'h01;
            p = a[7:0];
            for (int e = 0; e < 8; e++) begin
                if (e != 0) inv_v = gf_mul(inv_v, p);
                p = gf_mul(p, p);
            end
            if (a == 0) inv_v = 8'h00;
            s = inv_v ^ {inv_v[6:0], inv_v[7]} ^ {inv_v[5:0], inv_v[7:6]}
                ^ {inv_v[4:0], inv_v[7:5]} ^ {inv_v[3:0], inv_v[7:4]} ^ 8'h63;
            fwd_box[a] = s;
            inv_box[s] = a[7:0];
        end
    end

    function automatic int num_rounds();
        return (key_len_reg == KLEN_SAT) ? 14 : 10 + 2 * key_len_reg;
    endfunction

    function automatic logic [31:0] subst_word(input logic [31:0] w);
        return {fwd_box[w[31:24]], fwd_box[w[23:16]], fwd_box[w[15:8]], fwd_box[w[7:0]]};
    endfunction

    function automatic void build_schedule();
        int nr, nk, total;
        logic [7:0]  rc;
        logic [31:0] t;
        nr = num_rounds();
        nk = nr - 6;
        total = 4 * (nr + 1);
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            sched[i] = i[0] ? key_regs[i >> 1][31:0] : key_regs[i >> 1][63:32];
        for (int i = nk; i < total; i++) begin
            t = sched[i - 1];
            if (i % nk == 0) begin
                t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = xtime(rc);
            end else if (nk == 8 && i % nk == 4) begin
                t = subst_word(t);
            end
            sched[i] = sched[i - nk] ^ t;
        end
    endfunction

    // byte i of the state sits at bits [127-8i -: 8]
    function automatic logic [127:0] add_round_key(input logic [127:0] s, input int rnd);
        for (int c = 0; c < 4; c++)
            s[127 - 32 * c -: 32] ^= sched[4 * rnd + c];
        return s;
    endfunction

    function automatic logic [127:0] subst_all(input logic [127:0] s, input bit inv);
        for (int i = 0; i < 16; i++)
            s[127 - 8 * i -: 8] = inv ? inv_box[s[127 - 8 * i -: 8]] : fwd_box[s[127 - 8 * i -: 8]];
        return s;
    endfunction

    function automatic logic [127:0] shift_all(input logic [127:0] s, input bit inv);
        logic [127:0] o;
        int src;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                src = ((c + r) & 3) * 4 + r;
                if (inv) o[127 - 8 * src -: 8] = s[127 - 8 * (4 * c + r) -: 8];
                else     o[127 - 8 * (4 * c + r) -: 8] = s[127 - 8 * src -: 8];
            end
        return o;
    endfunction

    function automatic logic [127:0] mix_all(input logic [127:0] s, input bit inv);
        logic [7:0] mf [4], mi [4], a [4], v;
        logic [127:0] o;
        mf = '{8'h02, 8'h03, 8'h01, 8'h01};
        mi = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) a[k] = s[127 - 8 * (4 * c + k) -: 8];
            for (int r = 0; r < 4; r++) begin
                v = '0;
                for (int k = 0; k < 4; k++)
                    v ^= gf_mul(a[k], inv ? mi[(k - r) & 3] : mf[(k - r) & 3]);
                o[127 - 8 * (4 * c + r) -: 8] = v;
            end
        end
        return o;
    endfunction

    function automatic t_cipher_out cipher_block(input logic func, input logic [63:0] hi,
                                                 input logic [63:0] lo);
        logic [127:0] s;
        int nr;
        t_cipher_out r;
        build_schedule();
        nr = num_rounds();
        s = {hi, lo};
        if (func == FUNC_ENC) begin
            s = add_round_key(s, 0);
            for (int rnd = 1; rnd <= nr; rnd++) begin
                s = shift_all(subst_all(s, 0), 0);
                if (rnd != nr) s = mix_all(s, 0);
                s = add_round_key(s, rnd);
            end
        end else begin
            s = add_round_key(s, nr);
            for (int rnd = nr - 1; rnd >= 0; rnd--) begin
                s = add_round_key(subst_all(shift_all(s, 1), 1), rnd);
                if (rnd != 0) s = mix_all(s, 1);
            end
        end
        r.hi = s[127:64];
        r.lo = s[63:0];
        return r;
    endfunction

    function automatic void write_key_reg(input logic [2:0] idx, input logic [63:0] data);
        if (idx == CFG_KEY_LENGTH) key_len_reg = data[1:0];
        else if (idx <= CFG_KEY_WORD_3) key_regs[idx - CFG_KEY_WORD_0] = data;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus plan
    // ---------------------------------------------------------------
    function automatic int pick_gap(input bit no_idle);
        int roll;
        roll = $urandom_range(99);
        if (no_idle || roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 6);
        return $urandom_range(20, 300);
    endfunction

    function automatic void add_block(input logic func, input logic [63:0] hi,
                                      input logic [63:0] lo, input bit no_idle);
        t_stim_item it;
        it = '{kind: ITEM_BLOCK, func: func, hi: hi, lo: lo, idx: CFG_KEY_LENGTH,
               data: '0, gap: pick_gap(no_idle)};
        work_q.push_back(it);
    endfunction

    function automatic void add_cfg(input logic [2:0] idx, input logic [63:0] data);
        t_stim_item it;
        it = '{kind: ITEM_CFG, func: FUNC_ENC, hi: '0, lo: '0, idx: idx, data: data,
               gap: pick_gap(0)};
        work_q.push_back(it);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void add_key_setup(input logic [1:0] klen, input int pattern);
        logic [63:0] kw;
        logic [63:0] junk;
        // upper data bits of the length write are junk the block must ignore
        junk = rand64();
        add_cfg(CFG_KEY_LENGTH, {junk[63:2], klen});
        for (int w = 0; w < 4; w++) begin
            case (pattern)
                0:       kw = '0;
                1:       kw = '1;
                default: kw = rand64();
            endcase
            add_cfg(CFG_KEY_WORD_0 + w[2:0], kw);
        end
        add_cfg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), rand64());
    endfunction

    initial begin
        logic [1:0] klens [8];
        bit quiet_phase;
        klens = '{KLEN_128, KLEN_192, KLEN_256, KLEN_SAT, KLEN_256, KLEN_128, KLEN_192,
                  KLEN_256};
        // directed: reset key, extremes of the block, both operations
        foreach (klens[i]) if (i < 2) begin end
        add_block(FUNC_ENC, '0, '0, 0);
        add_block(FUNC_DEC, '0, '0, 0);
        add_block(FUNC_ENC, '1, '1, 0);
        add_block(FUNC_DEC, '1, '1, 0);
        add_block(FUNC_ENC, 64'h00112233_44556677, 64'h8899aabb_ccddeeff, 1);
        add_block(FUNC_DEC, 64'haaaaaaaa_aaaaaaaa, 64'h55555555_55555555, 1);
        // every length with all-zero and all-one keys, the saturating code too
        for (int p = 0; p < 2; p++)
            for (int k = 0; k < 4; k++) begin
                add_key_setup(k[1:0], p);
                add_block(FUNC_ENC, '0, '1, 0);
                add_block(FUNC_DEC, '1, '0, 0);
            end
        // random phases over several key settings
        for (int ph = 0; ph < 16; ph++) begin
            add_key_setup(klens[ph % 8], 2);
            quiet_phase = (ph % 4 == 1);
            for (int n = 0; n < 70; n++) begin
                add_block(1'($urandom_range(1)), rand64(), rand64(), quiet_phase);
                // sender holds off until the block has emptied out
                if (n == 35 && ph % 3 == 0) begin
                    t_stim_item it;
                    it = '{kind: ITEM_DRAIN, func: FUNC_ENC, hi: '0, lo: '0,
                           idx: CFG_KEY_LENGTH, data: '0, gap: 0};
                    work_q.push_back(it);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Driver: one nonblocking assignment per signal per edge
    // ---------------------------------------------------------------
    int         gap_left = 0;
    int         quiet_cycles = 0;
    logic       nxt_start, nxt_cfg_valid;
    t_stim_item head;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_cfg_valid <= 1'b0;
            gap_left = 0;
            quiet_cycles = 0;
        end else begin
            nxt_start = i_start;
            nxt_cfg_valid = i_cfg_valid;
            // block transfer: predict right away with the current key
            if (i_start && !o_busy) begin
                pending_q.push_back(cipher_block(i_func, i_block_hi, i_block_lo));
                nxt_start = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                write_key_reg(i_cfg_index, i_cfg_data);
                nxt_cfg_valid = 1'b0;
            end
            if (pending_q.size() == 0 && !o_busy && !nxt_start) quiet_cycles++;
            else quiet_cycles = 0;
            if (!nxt_start && !nxt_cfg_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (work_q.size() > 0) begin
                    head = work_q[0];
                    if (head.kind == ITEM_BLOCK) begin
                        void'(work_q.pop_front());
                        i_func <= head.func;
                        i_block_hi <= head.hi;
                        i_block_lo <= head.lo;
                        nxt_start = 1'b1;
                        gap_left = head.gap;
                    end else if (quiet_cycles >= SETTLE) begin
                        // config and drain both need an idle, settled block
                        void'(work_q.pop_front());
                        if (head.kind == ITEM_CFG) begin
                            i_cfg_index <= head.idx;
                            i_cfg_data <= head.data;
                            nxt_cfg_valid = 1'b1;
                            gap_left = head.gap;
                        end
                    end
                end
            end
            i_start <= nxt_start;
            i_cfg_valid <= nxt_cfg_valid;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: results cannot stall, so each strobe is one transfer
    // ---------------------------------------------------------------
    t_cipher_out want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result hi=%h lo=%h", $time, o_out_hi, o_out_lo);
                fail_count++;
            end else begin
                want = pending_q.pop_front();
                if (o_out_hi !== want.hi) begin
                    $display("%0t: out_hi expected %h actual %h", $time, want.hi, o_out_hi);
                    fail_count++;
                end
                if (o_out_lo !== want.lo) begin
                    $display("%0t: out_lo expected %h actual %h", $time, want.lo, o_out_lo);
                    fail_count++;
                end
            end
        end
    end

    // reset, then wait for the plan to drain
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk);
        while (work_q.size() != 0 || i_start || i_cfg_valid || pending_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
        if (pending_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_q.size());
            fail_count++;
        end
        if (fail_count == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #30ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

// ----- aes_block_cipher.f -----
+incdir+hdl
hdl/aes_pkg.sv
hdl/aes_key_exp.sv
hdl/aes_round.sv
hdl/aes_block_cipher.sv
hdl/aes_chk.sv
tb/aes_block_cipher_tb.sv
